// File: rtl/pcsv_pkg.sv
// Shared types, constants and helper functions of the PNG chunk stream validator.
package pcsv_pkg;

  localparam int OFFSET_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;
  localparam int          SIG_LEN  = 8;
  localparam int          HDR_LEN  = 8;
  localparam int          LEN_LEN  = 4;
  localparam int          CRC_LEN  = 4;
  localparam int          CAP_LEN  = 13;
  localparam logic [31:0] IHDR_LEN = 32'd13;
  localparam logic [31:0] POS_MISSING = 32'd8;

  localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
    8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a
  };

  localparam logic [31:0] T_IHDR = 32'h49484452;
  localparam logic [31:0] T_IDAT = 32'h49444154;
  localparam logic [31:0] T_IEND = 32'h49454e44;

  // record kinds
  localparam logic [1:0] RK_ISSUE   = 2'd0;
  localparam logic [1:0] RK_CHUNK   = 2'd1;
  localparam logic [1:0] RK_SUMMARY = 2'd2;

  // issue codes
  localparam int NUM_ISSUES = 19;
  localparam logic [4:0] IC_INVALID_SIGNATURE   = 5'd0;
  localparam logic [4:0] IC_TRUNC_HEADER        = 5'd1;
  localparam logic [4:0] IC_INVALID_TYPE        = 5'd2;
  localparam logic [4:0] IC_TRUNC_CHUNK         = 5'd3;
  localparam logic [4:0] IC_CRC_MISMATCH        = 5'd4;
  localparam logic [4:0] IC_IHDR_NOT_FIRST      = 5'd5;
  localparam logic [4:0] IC_DUP_IHDR            = 5'd6;
  localparam logic [4:0] IC_IHDR_LENGTH         = 5'd7;
  localparam logic [4:0] IC_DIMENSIONS          = 5'd8;
  localparam logic [4:0] IC_COMPRESSION         = 5'd9;
  localparam logic [4:0] IC_FILTER              = 5'd10;
  localparam logic [4:0] IC_INTERLACE           = 5'd11;
  localparam logic [4:0] IC_COLOR_DEPTH         = 5'd12;
  localparam logic [4:0] IC_NONCONSEC_IDAT      = 5'd13;
  localparam logic [4:0] IC_IEND_LENGTH         = 5'd14;
  localparam logic [4:0] IC_TRAILING            = 5'd15;
  localparam logic [4:0] IC_MISSING_IHDR        = 5'd16;
  localparam logic [4:0] IC_MISSING_IDAT        = 5'd17;
  localparam logic [4:0] IC_MISSING_IEND        = 5'd18;

  // seen flags
  localparam int NUM_FLAGS  = 7;
  localparam int FL_CHUNK   = 0;
  localparam int FL_IHDR    = 1;
  localparam int FL_IDAT    = 2;
  localparam int FL_IDATEND = 3;
  localparam int FL_IEND    = 4;
  localparam int FL_CRCBAD  = 5;
  localparam int FL_TRUNC   = 6;

  // result mask of one item: chunk record, then issues by code, then summary
  localparam int MB_REC    = 0;
  localparam int MB_ISSUE0 = 1;
  localparam int MB_SUM    = MB_ISSUE0 + NUM_ISSUES;
  localparam int MB_NUM    = MB_SUM + 1;
  localparam int MB_IW     = $clog2(MB_NUM);

  typedef enum logic [5:0] {
    PH_SIG    = 6'b000001,
    PH_HDR    = 6'b000010,
    PH_DATA   = 6'b000100,
    PH_CRC    = 6'b001000,
    PH_TAIL   = 6'b010000,
    PH_BADSIG = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [4:0]  issue_code;
    logic [31:0] position;
    logic [31:0] type_word;
    logic [31:0] declared_length;
    logic [31:0] crc_from_file;
    logic [31:0] crc_worked_out;
    logic        crc_match;
    logic        signature_good;
    logic        parse_finished;
    logic        every_crc_good;
    logic        end_of_burst;
  } out_t;

  typedef struct packed {
    logic [MB_NUM-1:0] mask;
    logic [31:0]       pos_chunk;
    logic [31:0]       pos_type;
    logic [31:0]       pos_end;
    logic [31:0]       type_word;
    logic [31:0]       declared_length;
    logic [31:0]       crc_from_file;
    logic [31:0]       crc_worked_out;
    logic              crc_match;
    logic              signature_good;
    logic              parse_finished;
    logic              every_crc_good;
  } event_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic depth_ok(input logic [7:0] color, input logic [7:0] depth);
    logic ok;
    case (color)
      8'd0: ok = depth == 8'd1 || depth == 8'd2 || depth == 8'd4 || depth == 8'd8 ||
                 depth == 8'd16;
      8'd2, 8'd4, 8'd6: ok = depth == 8'd8 || depth == 8'd16;
      8'd3: ok = depth == 8'd1 || depth == 8'd2 || depth == 8'd4 || depth == 8'd8;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// File: rtl/png_chunk_stream_validator_top.sv
// Top level of the PNG chunk stream validator: parser, event queue and record sequencer.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | in_data  (pcsv_pkg::in_t: data_byte, last_byte)
//  out_    | output    | out_valid/out_ready  | out_data (pcsv_pkg::out_t: one record)
//
//  One byte is taken per cycle while the event queue has room; the back end sends the result
//  items of one event one at a time through the output register, holding while out_ready is low.
//  Input stalls only when QUEUE_DEPTH events with unsent results are waiting.
//  Reset (rst_n low, synchronous) returns the parser to the signature phase and empties
//  the queue; after each file's summary the parser starts over on its own.
module png_chunk_stream_validator_top #(
  parameter int OFFSET_WIDTH = pcsv_pkg::OFFSET_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = pcsv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pcsv_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pcsv_pkg::out_t out_data
);

  logic ev_valid, ev_ready, head_valid, pop;
  pcsv_pkg::event_t ev_data, head_data;

  pcsv_front #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .ev_valid(ev_valid), .ev_ready(ev_ready), .ev_data(ev_data)
  );

  pcsv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(ev_valid), .push_ready(ev_ready), .push_data(ev_data),
    .pop(pop), .head_valid(head_valid), .head_data(head_data)
  );

  pcsv_back u_back (
    .clk(clk), .rst_n(rst_n),
    .head_valid(head_valid), .head_data(head_data), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

// File: rtl/pcsv_front.sv
// Front end: byte parser that classifies each byte and queues one event of results for each byte that yields any.
module pcsv_front #(
  parameter int OFFSET_WIDTH = pcsv_pkg::OFFSET_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pcsv_pkg::in_t    in_data,
  output logic             ev_valid,
  input  logic             ev_ready,
  output pcsv_pkg::event_t ev_data
);

  localparam int OW = OFFSET_WIDTH;

  pcsv_pkg::phase_t phase_r, phase_nxt;
  logic [OW-1:0] off_r, off_nxt, cs_r, cs_nxt, cs_eff;
  logic [3:0]  sidx_r, sidx_nxt;
  logic [31:0] fbc_r, fbc_nxt;
  logic [31:0] len_r, len_nxt, type_r, type_nxt, crc_r, crc_nxt, stc_r, stc_nxt;
  logic [31:0] len_b, type_b, crc_b, stc_shift, computed;
  logic [pcsv_pkg::NUM_FLAGS-1:0] flags_r, flags_nxt;
  logic [7:0] cap_r [pcsv_pkg::CAP_LEN];
  logic [pcsv_pkg::NUM_ISSUES-1:0] iss;
  logic rec, sum, sig_ok, cap_we, match, fire, b_last;
  logic is_ihdr, is_idat, is_iend;
  logic [7:0] b;

  assign b       = in_data.data_byte;
  assign b_last  = in_data.last_byte;
  assign in_ready = ev_ready;
  assign fire    = in_valid && in_ready;

  assign cs_eff    = (phase_r == pcsv_pkg::PH_HDR && fbc_r == 32'd0) ? off_r : cs_r;
  assign stc_shift = {stc_r[23:0], b};
  assign computed  = ~crc_r;
  assign match     = computed == stc_shift;
  assign is_ihdr   = type_r == pcsv_pkg::T_IHDR;
  assign is_idat   = type_r == pcsv_pkg::T_IDAT;
  assign is_iend   = type_r == pcsv_pkg::T_IEND;

  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    sidx_nxt  = sidx_r;
    fbc_nxt   = fbc_r;
    cs_nxt    = cs_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    crc_nxt   = crc_r;
    stc_nxt   = stc_r;
    flags_nxt = flags_r;
    iss       = '0;
    rec       = 1'b0;
    sum       = 1'b0;
    sig_ok    = 1'b1;
    cap_we    = 1'b0;
    len_b     = len_r;
    type_b    = type_r;
    crc_b     = crc_r;
    case (phase_r)
      pcsv_pkg::PH_SIG: begin
        if (b != pcsv_pkg::SIG_BYTES[sidx_r[2:0]]) begin
          iss[pcsv_pkg::IC_INVALID_SIGNATURE] = 1'b1;
          phase_nxt = pcsv_pkg::PH_BADSIG;
          sig_ok    = 1'b0;
        end else begin
          sidx_nxt = sidx_r + 4'd1;
          if (sidx_r == 4'(pcsv_pkg::SIG_LEN - 1)) begin
            phase_nxt = pcsv_pkg::PH_HDR;
            fbc_nxt   = '0;
          end else if (b_last) begin
            iss[pcsv_pkg::IC_INVALID_SIGNATURE] = 1'b1;
            sig_ok = 1'b0;
          end
        end
      end
      pcsv_pkg::PH_HDR: begin
        if (fbc_r == 32'd0) begin
          cs_nxt = off_r;
          len_b  = '0;
          type_b = '0;
          crc_b  = pcsv_pkg::CRC_INIT;
        end
        len_nxt  = len_b;
        type_nxt = type_b;
        crc_nxt  = crc_b;
        if (fbc_r < 32'(pcsv_pkg::LEN_LEN)) begin
          len_nxt = {len_b[23:0], b};
        end else begin
          type_nxt = {type_b[23:0], b};
          crc_nxt  = pcsv_pkg::crc_byte(crc_b, b);
        end
        fbc_nxt = fbc_r + 32'd1;
        if (fbc_r < 32'(pcsv_pkg::HDR_LEN - 1)) begin
          if (b_last) begin
            flags_nxt[pcsv_pkg::FL_TRUNC] = 1'b1;
            iss[pcsv_pkg::IC_TRUNC_HEADER] = 1'b1;
          end
        end else begin
          if (!pcsv_pkg::is_letter(type_nxt[31:24]) || !pcsv_pkg::is_letter(type_nxt[23:16]) ||
              !pcsv_pkg::is_letter(type_nxt[15:8])  || !pcsv_pkg::is_letter(type_nxt[7:0]))
            iss[pcsv_pkg::IC_INVALID_TYPE] = 1'b1;
          fbc_nxt   = '0;
          stc_nxt   = '0;
          phase_nxt = (len_b == 32'd0) ? pcsv_pkg::PH_CRC : pcsv_pkg::PH_DATA;
          if (b_last) begin
            flags_nxt[pcsv_pkg::FL_TRUNC] = 1'b1;
            iss[pcsv_pkg::IC_TRUNC_CHUNK] = 1'b1;
          end
        end
      end
      pcsv_pkg::PH_DATA: begin
        crc_nxt = pcsv_pkg::crc_byte(crc_r, b);
        cap_we  = fbc_r < 32'(pcsv_pkg::CAP_LEN);
        fbc_nxt = fbc_r + 32'd1;
        if ({1'b0, fbc_r} + 33'd1 >= {1'b0, len_r}) begin
          fbc_nxt   = '0;
          phase_nxt = pcsv_pkg::PH_CRC;
        end
        if (b_last) begin
          flags_nxt[pcsv_pkg::FL_TRUNC] = 1'b1;
          iss[pcsv_pkg::IC_TRUNC_CHUNK] = 1'b1;
        end
      end
      pcsv_pkg::PH_CRC: begin
        stc_nxt = stc_shift;
        fbc_nxt = fbc_r + 32'd1;
        if (fbc_r >= 32'(pcsv_pkg::CRC_LEN - 1)) begin
          rec = 1'b1;
          if (!match) begin
            flags_nxt[pcsv_pkg::FL_CRCBAD] = 1'b1;
            iss[pcsv_pkg::IC_CRC_MISMATCH] = 1'b1;
          end
          if (!flags_r[pcsv_pkg::FL_CHUNK] && !is_ihdr) iss[pcsv_pkg::IC_IHDR_NOT_FIRST] = 1'b1;
          flags_nxt[pcsv_pkg::FL_CHUNK] = 1'b1;
          if (is_ihdr) begin
            if (flags_r[pcsv_pkg::FL_IHDR]) iss[pcsv_pkg::IC_DUP_IHDR] = 1'b1;
            flags_nxt[pcsv_pkg::FL_IHDR] = 1'b1;
            if (len_r != pcsv_pkg::IHDR_LEN) begin
              iss[pcsv_pkg::IC_IHDR_LENGTH] = 1'b1;
            end else begin
              if ({cap_r[0], cap_r[1], cap_r[2], cap_r[3]} == 32'd0 ||
                  {cap_r[4], cap_r[5], cap_r[6], cap_r[7]} == 32'd0)
                iss[pcsv_pkg::IC_DIMENSIONS] = 1'b1;
              if (cap_r[10] != 8'd0) iss[pcsv_pkg::IC_COMPRESSION] = 1'b1;
              if (cap_r[11] != 8'd0) iss[pcsv_pkg::IC_FILTER] = 1'b1;
              if (cap_r[12] > 8'd1) iss[pcsv_pkg::IC_INTERLACE] = 1'b1;
              if (!pcsv_pkg::depth_ok(cap_r[9], cap_r[8])) iss[pcsv_pkg::IC_COLOR_DEPTH] = 1'b1;
            end
          end
          if (is_idat) begin
            if (flags_r[pcsv_pkg::FL_IDATEND]) iss[pcsv_pkg::IC_NONCONSEC_IDAT] = 1'b1;
            flags_nxt[pcsv_pkg::FL_IDAT] = 1'b1;
          end else if (flags_r[pcsv_pkg::FL_IDAT]) begin
            flags_nxt[pcsv_pkg::FL_IDATEND] = 1'b1;
          end
          if (is_iend) begin
            flags_nxt[pcsv_pkg::FL_IEND] = 1'b1;
            if (len_r != 32'd0) iss[pcsv_pkg::IC_IEND_LENGTH] = 1'b1;
            if (!b_last) iss[pcsv_pkg::IC_TRAILING] = 1'b1;
            phase_nxt = pcsv_pkg::PH_TAIL;
          end else begin
            phase_nxt = pcsv_pkg::PH_HDR;
          end
          fbc_nxt = '0;
        end else if (b_last) begin
          flags_nxt[pcsv_pkg::FL_TRUNC] = 1'b1;
          iss[pcsv_pkg::IC_TRUNC_CHUNK] = 1'b1;
        end
      end
      pcsv_pkg::PH_BADSIG: sig_ok = 1'b0;
      default: ;
    endcase

    ev_data.signature_good = 1'b0;
    ev_data.parse_finished = 1'b0;
    ev_data.every_crc_good = 1'b0;
    if (b_last) begin
      sum = 1'b1;
      if (sig_ok) begin
        iss[pcsv_pkg::IC_MISSING_IHDR] = !flags_nxt[pcsv_pkg::FL_IHDR];
        iss[pcsv_pkg::IC_MISSING_IDAT] = !flags_nxt[pcsv_pkg::FL_IDAT];
        iss[pcsv_pkg::IC_MISSING_IEND] = !flags_nxt[pcsv_pkg::FL_IEND];
      end
      ev_data.signature_good = sig_ok;
      ev_data.parse_finished = sig_ok && !flags_nxt[pcsv_pkg::FL_TRUNC];
      ev_data.every_crc_good = sig_ok && flags_nxt[pcsv_pkg::FL_CHUNK] &&
                               !flags_nxt[pcsv_pkg::FL_CRCBAD];
      // start over for the next file
      phase_nxt = pcsv_pkg::PH_SIG;
      off_nxt   = '0;
      sidx_nxt  = '0;
      fbc_nxt   = '0;
      cs_nxt    = '0;
      len_nxt   = '0;
      type_nxt  = '0;
      crc_nxt   = pcsv_pkg::CRC_INIT;
      stc_nxt   = '0;
      flags_nxt = '0;
    end else begin
      off_nxt = off_r + OW'(1);
    end

    ev_data.mask            = {sum, iss, rec};
    ev_data.pos_chunk       = 32'(cs_eff);
    ev_data.pos_type        = 32'(cs_eff + OW'(4));
    ev_data.pos_end         = 32'(off_r + OW'(1));
    ev_data.type_word       = type_r;
    ev_data.declared_length = len_r;
    ev_data.crc_from_file   = stc_shift;
    ev_data.crc_worked_out  = computed;
    ev_data.crc_match       = match;
  end

  assign ev_valid = fire && (ev_data.mask != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pcsv_pkg::PH_SIG;
      off_r   <= '0;
      sidx_r  <= '0;
      fbc_r   <= '0;
      cs_r    <= '0;
      len_r   <= '0;
      type_r  <= '0;
      crc_r   <= pcsv_pkg::CRC_INIT;
      stc_r   <= '0;
      flags_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      sidx_r  <= sidx_nxt;
      fbc_r   <= fbc_nxt;
      cs_r    <= cs_nxt;
      len_r   <= len_nxt;
      type_r  <= type_nxt;
      crc_r   <= crc_nxt;
      stc_r   <= stc_nxt;
      flags_r <= flags_nxt;
    end
  end

  // IHDR field bytes: capture the first data bytes of every chunk
  always_ff @(posedge clk) begin
    if (fire && cap_we) cap_r[fbc_r[3:0]] <= b;
  end

endmodule

// File: rtl/pcsv_queue.sv
// Short event queue between the parser and the record sequencer.
module pcsv_queue #(
  parameter int DEPTH = pcsv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             push_ready,
  input  pcsv_pkg::event_t push_data,
  input  logic             pop,
  output logic             head_valid,
  output pcsv_pkg::event_t head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pcsv_pkg::event_t mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  assign push_ready = cnt_r != CW'(DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_data  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      if (pop)  rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != CW'(DEPTH)) else $error("event queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("event queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("event queue count out of range");

endmodule

// File: rtl/pcsv_back.sv
// Back end: expands one queued event into its result items, one per cycle while the output register can load.
module pcsv_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  pcsv_pkg::event_t head_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output pcsv_pkg::out_t   out_data
);

  localparam int N = pcsv_pkg::MB_NUM;

  logic [N-1:0] done_r, done_nxt, pend, pick;
  logic [pcsv_pkg::MB_IW-1:0] idx;
  logic out_valid_r, can_load, emit, last_one;
  pcsv_pkg::out_t out_r, rec;
  logic [4:0] code;

  assign pend     = head_valid ? (head_data.mask & ~done_r) : '0;
  assign pick     = pend & (~pend + N'(1));
  assign can_load = !out_valid_r || out_ready;
  assign emit     = head_valid && can_load;
  assign last_one = (pend & ~pick) == '0;
  assign pop      = emit && last_one;
  assign done_nxt = pop ? '0 : (emit ? (done_r | pick) : done_r);

  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (pick[i]) idx = pcsv_pkg::MB_IW'(i);
    end
  end

  assign code = 5'(idx - pcsv_pkg::MB_IW'(pcsv_pkg::MB_ISSUE0));

  always_comb begin
    rec = '0;
    rec.end_of_burst = last_one;
    if (idx == pcsv_pkg::MB_IW'(pcsv_pkg::MB_REC)) begin
      rec.record_kind     = pcsv_pkg::RK_CHUNK;
      rec.position        = head_data.pos_chunk;
      rec.type_word       = head_data.type_word;
      rec.declared_length = head_data.declared_length;
      rec.crc_from_file   = head_data.crc_from_file;
      rec.crc_worked_out  = head_data.crc_worked_out;
      rec.crc_match       = head_data.crc_match;
    end else if (idx == pcsv_pkg::MB_IW'(pcsv_pkg::MB_SUM)) begin
      rec.record_kind    = pcsv_pkg::RK_SUMMARY;
      rec.signature_good = head_data.signature_good;
      rec.parse_finished = head_data.parse_finished;
      rec.every_crc_good = head_data.every_crc_good;
    end else begin
      rec.record_kind = pcsv_pkg::RK_ISSUE;
      rec.issue_code  = code;
      case (code)
        pcsv_pkg::IC_INVALID_SIGNATURE: rec.position = '0;
        pcsv_pkg::IC_INVALID_TYPE:      rec.position = head_data.pos_type;
        pcsv_pkg::IC_TRAILING,
        pcsv_pkg::IC_MISSING_IEND:      rec.position = head_data.pos_end;
        pcsv_pkg::IC_MISSING_IHDR,
        pcsv_pkg::IC_MISSING_IDAT:      rec.position = pcsv_pkg::POS_MISSING;
        default:                        rec.position = head_data.pos_chunk;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= '0;
    end else begin
      done_r <= done_nxt;
      if (can_load) out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_r <= rec;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(pick)) else $error("more than one result picked");
  a_burst_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last_one) |=> done_r == '0) else $error("progress mask not cleared at burst end");
  a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> pend != '0) else $error("queued event with no pending result");

endmodule
